// ===== hw/rtl/rfaht_pkg.sv =====
// Package: shared types and constants for the reverse-flow alive host tracker
`default_nettype none
package rfaht_pkg;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_PUSH,
    ST_TAB_RD,
    ST_TAB_CHK,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/reverse_flow_alive_host_tracker.sv =====
// Top level: sequencer scanning the window and alive table memories
// Flow: a non-IPv4 request goes straight to the done state; an IPv4 request scans
//   the window, drops stale triples, pushes, and may then search the alive table.
// Throughput: one request at a time; in_ready rises the cycle after the result
//   register loads, and a finished request waits while that register is unread.
// Reset: synchronous rst empties window and table (counts to zero).
`default_nettype none
module reverse_flow_alive_host_tracker #(
  parameter int WINDOW_DEPTH = 64,
  parameter int ALIVE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        is_ipv4,
  input  wire logic [47:0] timestamp_us,
  input  wire logic [31:0] src_addr,
  input  wire logic [31:0] dst_addr,
  input  wire logic [7:0]  protocol,
  input  wire logic        tcp_syn,
  input  wire logic        tcp_ack,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             alive,
  output logic [31:0]      alive_addr,
  output logic             newly_added,
  output logic             table_full,
  output logic             window_overflow
);
  import rfaht_pkg::*;

  localparam int WAW = $clog2(WINDOW_DEPTH);
  localparam int WCW = $clog2(WINDOW_DEPTH + 1);
  localparam int AAW = $clog2(ALIVE_DEPTH);
  localparam int ACW = $clog2(ALIVE_DEPTH + 1);

  state_t state, state_next;
  logic [31:0] match_interval;
  logic [WAW-1:0] head;
  logic [WCW-1:0] wcount;
  logic [ACW-1:0] acount;
  logic [WCW-1:0] idx;
  logic [ACW-1:0] aidx;
  logic first_drop;
  // request capture
  logic [47:0] r_ts;
  logic [31:0] r_src, r_dst;
  logic [7:0]  r_proto;
  logic r_synack, r_alive, r_ovf, r_added, r_full;

  logic [47:0] m_time;
  logic [31:0] m_src, m_dst, a_data;
  logic [WAW-1:0] w_raddr, w_waddr;
  logic w_we, a_we;
  logic [48:0] age_diff;
  logic [47:0] age;
  logic known_proto;
  logic drop_now;
  logic tab_end, tab_hit;
  logic out_load;

  assign in_ready = (state == ST_IDLE);
  assign known_proto = (r_proto == PROTO_ICMP) || (r_proto == PROTO_TCP) ||
                       (r_proto == PROTO_UDP);

  // Age of the entry just read, clamped at zero
  assign age_diff = {1'b0, r_ts} - {1'b0, m_time};
  assign age = age_diff[48] ? 48'd0 : age_diff[47:0];

  // First drop needs strictly older, later ones at least the interval
  assign drop_now = first_drop ? (age > {16'd0, match_interval})
                               : (age >= {16'd0, match_interval});

  // Table scan ends at the fill count or on a matching address
  assign tab_end = (aidx == acount);
  assign tab_hit = !tab_end && (a_data == r_src);

  // Result register loads when empty or being taken
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // Window addressing: offset from head, wrapped
  function automatic logic [WAW-1:0] wrap(input logic [WAW-1:0] h, input logic [WCW-1:0] o);
    logic [WCW:0] s;
    s = {{(WCW+1-WAW){1'b0}}, h} + {1'b0, o};
    if (s >= (WCW+1)'(WINDOW_DEPTH)) s = s - (WCW+1)'(WINDOW_DEPTH);
    return s[WAW-1:0];
  endfunction

  assign w_raddr = (state == ST_DROP_RD || state == ST_DROP_CHK) ? head : wrap(head, idx);
  assign w_waddr = wrap(head, wcount);
  assign w_we = (state == ST_PUSH);
  assign a_we = (state == ST_TAB_CHK) && tab_end && (acount != ACW'(ALIVE_DEPTH));

  rfaht_window_mem #(.DEPTH(WINDOW_DEPTH), .AW(WAW)) u_win (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wtime(r_ts), .wsrc(r_src), .wdst(r_dst),
    .raddr(w_raddr), .rtime(m_time), .rsrc(m_src), .rdst(m_dst)
  );

  rfaht_alive_mem #(.DEPTH(ALIVE_DEPTH), .AW(AAW)) u_tab (
    .clk(clk), .we(a_we), .waddr(acount[AAW-1:0]), .wdata(r_src),
    .raddr(aidx[AAW-1:0]), .rdata(a_data)
  );

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid && in_ready) state_next = is_ipv4 ? ST_SCAN_RD : ST_DONE;
      ST_SCAN_RD:  state_next = (idx == wcount) ? ST_DROP_RD : ST_SCAN_CHK;
      ST_SCAN_CHK: state_next = ST_SCAN_RD;
      ST_DROP_RD:  state_next = (wcount == '0) ? ST_PUSH : ST_DROP_CHK;
      ST_DROP_CHK: state_next = drop_now ? ST_DROP_RD : ST_PUSH;
      ST_PUSH:     state_next = ((r_alive || r_synack) && known_proto) ? ST_TAB_RD : ST_DONE;
      ST_TAB_RD:   state_next = ST_TAB_CHK;
      ST_TAB_CHK:  state_next = (tab_end || tab_hit) ? ST_DONE : ST_TAB_RD;
      ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      wcount <= '0;
      acount <= '0;
      match_interval <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) match_interval <= cfg_wdata;
      // Load the result when the register is free, release it once taken
      if (out_load) begin
        out_valid <= 1'b1;
        alive <= r_alive;
        alive_addr <= r_alive ? r_src : 32'd0;
        newly_added <= r_added;
        table_full <= r_full;
        window_overflow <= r_ovf;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            r_ts <= timestamp_us; r_src <= src_addr; r_dst <= dst_addr;
            r_proto <= protocol;
            r_synack <= (protocol == PROTO_TCP) && tcp_syn && tcp_ack;
            r_alive <= 1'b0; r_ovf <= 1'b0; r_added <= 1'b0; r_full <= 1'b0;
            idx <= '0; aidx <= '0; first_drop <= 1'b1;
          end
        end
        ST_SCAN_RD: ;
        ST_SCAN_CHK: begin
          // Reverse pair within interval
          if (m_dst == r_src && m_src == r_dst && age <= {16'd0, match_interval})
            r_alive <= 1'b1;
          idx <= idx + WCW'(1);
        end
        ST_DROP_RD: ;
        ST_DROP_CHK: begin
          // Drop the oldest triple while it is stale
          if (drop_now) begin
            head <= wrap(head, WCW'(1));
            wcount <= wcount - WCW'(1);
          end
          first_drop <= 1'b0;
        end
        ST_PUSH: begin
          // Overwrite oldest when full
          if (wcount == WCW'(WINDOW_DEPTH)) begin
            head <= wrap(head, WCW'(1));
            r_ovf <= 1'b1;
          end else begin
            wcount <= wcount + WCW'(1);
          end
          r_alive <= r_alive || r_synack;
        end
        ST_TAB_RD: ;
        ST_TAB_CHK: begin
          if (tab_end) begin
            if (acount == ACW'(ALIVE_DEPTH)) r_full <= 1'b1;
            else begin
              acount <= acount + ACW'(1);
              r_added <= 1'b1;
            end
          end else if (!tab_hit) begin
            aidx <= aidx + ACW'(1);
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rfaht_window_mem.sv =====
// Window memory: ring of (time, source, destination) triples, registered read
`default_nettype none
module rfaht_window_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [47:0]   wtime,
  input  wire logic [31:0]   wsrc,
  input  wire logic [31:0]   wdst,
  input  wire logic [AW-1:0] raddr,
  output logic      [47:0]   rtime,
  output logic      [31:0]   rsrc,
  output logic      [31:0]   rdst
);
  logic [111:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtime, wsrc, wdst};
    end
    {rtime, rsrc, rdst} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rfaht_alive_mem.sv =====
// Alive-address table memory with registered read
`default_nettype none
module rfaht_alive_mem #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rfaht_checker.sv =====
// Port-level checker for the tracker, bound to the top level
`default_nettype none
module rfaht_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic alive,
  input wire logic [31:0] alive_addr,
  input wire logic newly_added,
  input wire logic table_full
);
  // Result held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Payload steady while the result waits
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(alive) && $stable(alive_addr) &&
    $stable(newly_added) && $stable(table_full)) else $error("result changed");
  // Added and full exclusive
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(newly_added && table_full)) else $error("added and full");
  // Insertion implies alive
  a_ins: assert property (@(posedge clk) disable iff (rst)
    out_valid && (newly_added || table_full) |-> alive) else $error("insert without alive");
  // Address is zero unless alive
  a_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alive |-> alive_addr == 32'd0) else $error("address without alive");
endmodule

bind reverse_flow_alive_host_tracker rfaht_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .alive(alive),
  .alive_addr(alive_addr), .newly_added(newly_added), .table_full(table_full)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the reverse-flow alive host tracker: random and directed packets checked per result
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rfaht_pkg::*;

  localparam int WIN_DEPTH = 64;
  localparam int TAB_DEPTH = 256;
  localparam int RING_DEPTH = 64;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic        alive;
    logic [31:0] addr;
    logic        added;
    logic        full;
    logic        ovf;
  } verdict_t;

  // Scoreboard: predicts the tracker's verdict per packet and checks results
  class alive_scoreboard;
    logic [31:0] interval;
    logic [47:0] win_ts [WIN_DEPTH];
    logic [31:0] win_src [WIN_DEPTH];
    logic [31:0] win_dst [WIN_DEPTH];
    int          win_head;
    int          win_cnt;
    logic [31:0] known [TAB_DEPTH];
    int          known_cnt;
    verdict_t    exp_ring [RING_DEPTH];
    int          ring_rd;
    int          ring_wr;
    int          outstanding;
    int          errors;
    int          checked;

    function new();
      interval = '0;
      win_head = 0;
      win_cnt = 0;
      known_cnt = 0;
      ring_rd = 0;
      ring_wr = 0;
      outstanding = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [47:0] age(logic [47:0] now, logic [47:0] then);
      return (now >= then) ? now - then : 48'd0;
    endfunction

    // Predict the verdict for one accepted packet
    function void note_packet(logic v4, logic [47:0] ts, logic [31:0] s, logic [31:0] d,
                              logic [7:0] pr, logic syn, logic ack);
      verdict_t r;
      int k;
      logic hit;
      r = '0;
      if (v4) begin
        hit = 0;
        for (int i = 0; i < win_cnt; i++) begin
          k = (win_head + i) % WIN_DEPTH;
          if (win_dst[k] == s && win_src[k] == d && age(ts, win_ts[k]) <= {16'd0, interval})
            hit = 1;
        end
        // drop stale entries, then push
        if (win_cnt > 0 && age(ts, win_ts[win_head]) > {16'd0, interval}) begin
          win_head = (win_head + 1) % WIN_DEPTH;
          win_cnt--;
          while (win_cnt > 0 && age(ts, win_ts[win_head]) >= {16'd0, interval}) begin
            win_head = (win_head + 1) % WIN_DEPTH;
            win_cnt--;
          end
        end
        if (win_cnt >= WIN_DEPTH) begin
          win_head = (win_head + 1) % WIN_DEPTH;
          win_cnt--;
          r.ovf = 1;
        end
        k = (win_head + win_cnt) % WIN_DEPTH;
        win_ts[k] = ts;
        win_src[k] = s;
        win_dst[k] = d;
        win_cnt++;
        if (pr == PROTO_TCP && syn && ack) hit = 1;
        if (hit && (pr == PROTO_ICMP || pr == PROTO_TCP || pr == PROTO_UDP)) begin
          bit seen;
          seen = 0;
          for (int i = 0; i < known_cnt; i++) if (known[i] == s) seen = 1;
          if (!seen) begin
            if (known_cnt < TAB_DEPTH) begin
              known[known_cnt] = s;
              known_cnt++;
              r.added = 1;
            end else r.full = 1;
          end
        end
        r.alive = hit;
        r.addr = hit ? s : 32'd0;
      end
      exp_ring[ring_wr] = r;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      outstanding++;
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(verdict_t got);
      verdict_t exp_v;
      if (outstanding == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_v = exp_ring[ring_rd];
      ring_rd = (ring_rd + 1) % RING_DEPTH;
      outstanding--;
      checked++;
      if (got !== exp_v) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: alive %b/%b addr %h/%h added %b/%b full %b/%b ovf %b/%b",
                   checked, exp_v.alive, got.alive, exp_v.addr, got.addr, exp_v.added,
                   got.added, exp_v.full, got.full, exp_v.ovf, got.ovf);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 0, in_ready;
  logic is_ipv4 = 0;
  logic [47:0] timestamp_us = '0;
  logic [31:0] src_addr = '0, dst_addr = '0;
  logic [7:0] protocol = '0;
  logic tcp_syn = 0, tcp_ack = 0;
  logic out_valid, out_ready = 0;
  logic alive, newly_added, table_full, window_overflow;
  logic [31:0] alive_addr;

  alive_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;
  logic [47:0] now_ts = 48'd100;
  logic [31:0] hosts [16];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  reverse_flow_alive_host_tracker #(.WINDOW_DEPTH(WIN_DEPTH), .ALIVE_DEPTH(TAB_DEPTH)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .is_ipv4(is_ipv4),
    .timestamp_us(timestamp_us), .src_addr(src_addr), .dst_addr(dst_addr),
    .protocol(protocol), .tcp_syn(tcp_syn), .tcp_ack(tcp_ack),
    .out_valid(out_valid), .out_ready(out_ready), .alive(alive), .alive_addr(alive_addr),
    .newly_added(newly_added), .table_full(table_full), .window_overflow(window_overflow));

  // Collect results and drive the receiver's stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready)
      sb.check_result({alive, alive_addr, newly_added, table_full, window_overflow});
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_packet(logic v4, logic [47:0] ts, logic [31:0] s, logic [31:0] d,
                             logic [7:0] pr, logic syn, logic ack);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    is_ipv4 <= v4;
    timestamp_us <= ts;
    src_addr <= s;
    dst_addr <= d;
    protocol <= pr;
    tcp_syn <= syn;
    tcp_ack <= ack;
    do @(posedge clk); while (!in_ready);
    sb.note_packet(v4, ts, s, d, pr, syn, ack);
  endtask

  // Drop valid, wait for every outstanding result, then let the sequencer settle
  task automatic drain();
    in_valid <= 0;
    while (sb.outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_interval(logic [31:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    sb.interval = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(5)) inside
      0: return PROTO_ICMP;
      [1:2]: return PROTO_TCP;
      3: return PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random traffic: mostly request/reply pairs among a small host pool
  task automatic random_phase(int n, int idle, int stall, int step_max);
    logic [31:0] a, b;
    logic [7:0] pr;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      now_ts += 48'($urandom_range(step_max));
      a = ($urandom_range(9) == 0) ? $urandom : hosts[$urandom_range(15)];
      b = hosts[$urandom_range(15)];
      pr = pick_proto();
      send_packet($urandom_range(19) != 0, now_ts, a, b, pr,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      if ($urandom_range(1) != 0) begin
        now_ts += 48'($urandom_range(step_max));
        send_packet(1, now_ts, b, a, pr, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    foreach (hosts[i]) hosts[i] = $urandom;
    hosts[0] = '0;
    hosts[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: ignored packet, extremes, reply match, SYN+ACK, other protocol
    write_interval(32'd50);
    send_packet(0, '1, '1, '1, '1, 1, 1);
    send_packet(1, 48'd10, 32'h0A000001, 32'h0A000002, PROTO_ICMP, 0, 0);
    send_packet(1, 48'd60, 32'h0A000002, 32'h0A000001, PROTO_ICMP, 0, 0);
    send_packet(1, 48'd60, 32'h0A000002, 32'h0A000001, PROTO_UDP, 0, 0);
    send_packet(1, 48'd70, 32'h0A000003, 32'h0A000004, PROTO_TCP, 1, 1);
    send_packet(1, 48'd71, 32'h0A000005, 32'h0A000004, PROTO_TCP, 1, 0);
    send_packet(1, 48'd72, 32'h0A000004, 32'h0A000005, 8'd99, 0, 1);
    send_packet(1, 48'd65, 32'h0A000005, 32'h0A000004, PROTO_UDP, 0, 0);
    send_packet(1, 48'd200, '1, '0, PROTO_UDP, 0, 0);
    send_packet(1, 48'd250, '0, '1, PROTO_UDP, 0, 0);
    send_packet(1, 48'd251, '0, '1, PROTO_UDP, 0, 0);
    send_packet(1, '1, 32'h55555555, 32'hAAAAAAAA, PROTO_TCP, 1, 1);
    send_packet(1, '1, 32'hAAAAAAAA, 32'h55555555, PROTO_TCP, 0, 1);

    // Window overflow with interval at its maximum
    write_interval('1);
    now_ts = 48'd1000;
    for (int i = 0; i < 70; i++) send_packet(1, now_ts, 32'h100 + i, 32'h200, 8'd47, 0, 0);
    // Fill the alive table past its depth with fresh SYN+ACK sources
    for (int i = 0; i < TAB_DEPTH + 8; i++)
      send_packet(1, now_ts, 32'h01000000 + i, 32'h02000000, PROTO_TCP, 1, 1);

    // Random phases; pressure pause between them
    write_interval(32'd20);
    random_phase(100, 0, 0, 15);
    drain();
    write_interval(32'd0);
    random_phase(70, 61, 0, 3);
    write_interval(32'd500);
    random_phase(100, 0, 61, 100);
    write_interval('1);
    random_phase(65, 22, 22, 1000);
    write_interval(32'd5);
    random_phase(65, 0, 0, 8);

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d results over intervals 0, 5, 20, 50, 500 and max, with idling and stalls",
             sb.checked);
    $display("window overflow and alive table saturation were exercised");
    if (sb.errors == 0 && sb.outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== reverse_flow_alive_host_tracker.f =====
hw/rtl/rfaht_pkg.sv
hw/rtl/rfaht_window_mem.sv
hw/rtl/rfaht_alive_mem.sv
hw/rtl/reverse_flow_alive_host_tracker.sv
hw/rtl/rfaht_checker.sv
dv/testbench.sv
